[rtl/formant_speech_synth_top_assert.svh]
// Assertion macros used by the synthesizer controller RTL.
`ifndef FORMANT_SPEECH_SYNTH_TOP_ASSERT_SVH
`define FORMANT_SPEECH_SYNTH_TOP_ASSERT_SVH

// Condition in this cycle implies a consequence in the same cycle
`define FSS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fss assertion failed");

// Condition in this cycle implies a consequence in the next cycle
`define FSS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fss assertion failed");

`endif

[rtl/fss_pkg.sv]
`default_nettype none
package fss_pkg;

   localparam int NUM_STAGES = 5;
   localparam int NUM_FMT    = 5;
   localparam int NCOEF      = 2 * NUM_STAGES + 2;
   localparam int AMP_SLOT   = 2 * NUM_STAGES;
   localparam int PITCH_SLOT = 2 * NUM_STAGES + 1;
   localparam int STAGE_W    = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
   localparam int SLOT_W     = $clog2(NCOEF);

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic              capture;
      logic              start;
      logic              snap;
      logic              set_tgt;
      logic              div_init;
      logic              div_step;
      logic              div_store;
      logic [SLOT_W-1:0] slot;
      logic              tick_src;
      logic              stage_en;
      logic [STAGE_W-1:0] stage;
      logic [1:0]        phase;
      logic              coef_step;
   } dp_cmd_type;

   // Status back to the controller
   typedef struct packed {
      logic active;
      logic out_free;
   } dp_sts_type;

   localparam logic [6:0] AMP_TAB [16] = '{
      7'd0, 7'd1, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd7,
      7'd9, 7'd13, 7'd17, 7'd23, 7'd31, 7'd42, 7'd56, 7'd75};

   localparam logic [7:0] LEN_TAB [8] = '{
      8'd100, 8'd120, 8'd80, 8'd100, 8'd200, 8'd240, 8'd160, 8'd200};

   localparam logic [6:0] F_INIT [8] = '{
      7'd126, 7'd64, 7'd121, 7'd111, 7'd96, 7'd96, 7'd96, 7'd96};

   localparam logic [3:0] B_INIT [8] = '{
      4'd9, 4'd4, 4'd9, 4'd9, 4'd11, 4'd11, 4'd11, 4'd11};

   localparam logic [31:0] DEF_PITCH = {9'd0, 7'd30, 16'd0};

   localparam logic signed [14:0] POLE_TAB [128] = '{
      15'sd11424, 15'sd11400, 15'sd11377, 15'sd11331, 15'sd11285, 15'sd11265, 15'sd11195,
      15'sd11149, 15'sd11082, 15'sd11014, 15'sd10922, 15'sd10830, 15'sd10741, 15'sd10629,
      15'sd10491, 15'sd10332, 15'sd10172, 15'sd9992, 15'sd9788, 15'sd9560, 15'sd9311,
      15'sd9037, 15'sd8721, 15'sd8377, 15'sd8016, 15'sd7631, 15'sd7199, 15'sd6720,
      15'sd6245, 15'sd5721, 15'sd5197, 15'sd4654,
      -15'sd11245, -15'sd11200, -15'sd11131, -15'sd11064, -15'sd10995, -15'sd10905,
      -15'sd10813, -15'sd10700, -15'sd10585, -15'sd10447, -15'sd10291, -15'sd10108,
      -15'sd9924, -15'sd9722, -15'sd9470, -15'sd9223, -15'sd8928, -15'sd8609, -15'sd8247,
      -15'sd7881, -15'sd7472, -15'sd7019, -15'sd6566, -15'sd6068, -15'sd5545, -15'sd4999,
      -15'sd4452, -15'sd3902, -15'sd3363, -15'sd2844, -15'sd2316, -15'sd1864,
      15'sd11585, 15'sd11561, 15'sd11561, 15'sd11561, 15'sd11561, 15'sd11540, 15'sd11540,
      15'sd11540, 15'sd11515, 15'sd11515, 15'sd11494, 15'sd11470, 15'sd11470, 15'sd11448,
      15'sd11424, 15'sd11400, 15'sd11377, 15'sd11356, 15'sd11307, 15'sd11285, 15'sd11241,
      15'sd11195, 15'sd11149, 15'sd11082, 15'sd11014, 15'sd10943, 15'sd10874, 15'sd10784,
      15'sd10695, 15'sd10583, 15'sd10468, 15'sd10332, 15'sd10193, 15'sd10013, 15'sd9833,
      15'sd9628, 15'sd9399, 15'sd9155, 15'sd8876, 15'sd8584, 15'sd8218, 15'sd7857,
      15'sd7445, 15'sd6970, 15'sd6472, 15'sd5925, 15'sd5314, 15'sd4654, 15'sd3948,
      15'sd3178, 15'sd2312, 15'sd1429, 15'sd450, -15'sd543, -15'sd1614, -15'sd2729,
      -15'sd3883, -15'sd5066, -15'sd6250, -15'sd7404, -15'sd8500, -15'sd9497,
      -15'sd10359, -15'sd11038};

   localparam logic signed [14:0] DAMP_TAB [64] = '{
      15'sd8192, 15'sd8105, 15'sd7989, 15'sd7844, 15'sd7670, 15'sd7424, 15'sd7158,
      15'sd6803, 15'sd6370, 15'sd5860, 15'sd5252, 15'sd4579, 15'sd3824, 15'sd3057,
      15'sd2307, 15'sd1623,
      15'sd8193, 15'sd8100, 15'sd7990, 15'sd7844, 15'sd7672, 15'sd7423, 15'sd7158,
      15'sd6802, 15'sd6371, 15'sd5857, 15'sd5253, 15'sd4576, 15'sd3825, 15'sd3057,
      15'sd2309, 15'sd1617,
      -15'sd6739, -15'sd6476, -15'sd6141, -15'sd5738, -15'sd5225, -15'sd4604, -15'sd3872,
      -15'sd2975, -15'sd1930, -15'sd706, 15'sd686, 15'sd2224, 15'sd3871, 15'sd5518,
      15'sd6992, 15'sd8085,
      -15'sd6746, -15'sd6481, -15'sd6140, -15'sd5738, -15'sd5228, -15'sd4602, -15'sd3873,
      -15'sd2972, -15'sd1931, -15'sd705, 15'sd685, 15'sd2228, 15'sd3870, 15'sd5516,
      15'sd6993, 15'sd8084};

   // Product divided by 8192, rounded toward zero
   function automatic logic signed [16:0] trunc13(input logic signed [29:0] p);
      logic signed [29:0] adj;
      adj = p + (p[29] ? 30'sd8191 : 30'sd0);
      return 17'(adj >>> 13);
   endfunction

endpackage
`default_nettype wire

[rtl/fss_ctrl.sv]
`default_nettype none
module fss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_cmd,
   input  fss_pkg::dp_sts_type sts,
   output fss_pkg::dp_cmd_type ctl_cmd
);
   import fss_pkg::*;
   `include "formant_speech_synth_top_assert.svh"

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_LOAD_SNAP = 9'b000000010,
      ST_LOAD_TGT  = 9'b000000100,
      ST_DIV_INIT  = 9'b000001000,
      ST_DIV_STEP  = 9'b000010000,
      ST_DIV_STORE = 9'b000100000,
      ST_TICK_SRC  = 9'b001000000,
      ST_STAGE     = 9'b010000000,
      ST_OUT       = 9'b100000000
   } state_type;

   localparam logic [STAGE_W-1:0] STAGE_LAST = STAGE_W'(NUM_STAGES - 1);
   localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(NCOEF - 1);

   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [4:0]         bit_ff, bit_in;
   logic [STAGE_W-1:0] stage_ff, stage_in;
   logic [1:0]         phase_ff, phase_in;
   logic               accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      bit_in   = bit_ff;
      stage_in = stage_ff;
      phase_in = phase_ff;
      ctl_cmd  = '0;
      ctl_cmd.slot  = slot_ff;
      ctl_cmd.stage = stage_ff;
      ctl_cmd.phase = phase_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctl_cmd.capture = 1'b1;
               unique case (cmd_type'(req_cmd))
                  CMD_START: ctl_cmd.start = 1'b1;
                  CMD_LOAD:  state_in = ST_LOAD_SNAP;
                  CMD_TICK: begin
                     if (sts.active) state_in = ST_TICK_SRC;
                  end
                  default: ;
               endcase
            end
         end
         ST_LOAD_SNAP: begin
            ctl_cmd.snap = 1'b1;
            state_in = ST_LOAD_TGT;
         end
         ST_LOAD_TGT: begin
            ctl_cmd.set_tgt = 1'b1;
            slot_in  = '0;
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            ctl_cmd.div_init = 1'b1;
            bit_in   = '0;
            state_in = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            ctl_cmd.div_step = 1'b1;
            bit_in = bit_ff + 5'd1;
            if (bit_ff == 5'd31) state_in = ST_DIV_STORE;
         end
         ST_DIV_STORE: begin
            ctl_cmd.div_store = 1'b1;
            if (slot_ff == SLOT_LAST) begin
               state_in = ST_IDLE;
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = ST_DIV_INIT;
            end
         end
         ST_TICK_SRC: begin
            ctl_cmd.tick_src = 1'b1;
            stage_in = '0;
            phase_in = '0;
            state_in = ST_STAGE;
         end
         ST_STAGE: begin
            ctl_cmd.stage_en = 1'b1;
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd3) begin
               if (stage_ff == STAGE_LAST) state_in = ST_OUT;
               else stage_in = stage_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (sts.out_free) begin
               ctl_cmd.coef_step = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= '0;
         bit_ff   <= '0;
         stage_ff <= '0;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         bit_ff   <= bit_in;
         stage_ff <= stage_in;
         phase_ff <= phase_in;
      end
   end

   `FSS_ASSERT_NEXT(a_out_done, clock, reset, (state_ff == ST_OUT) && sts.out_free, state_ff == ST_IDLE)
   `FSS_ASSERT_NEXT(a_idle_tick, clock, reset, accept && (req_cmd == CMD_TICK) && !sts.active, state_ff == ST_IDLE)
   `FSS_ASSERT_NEXT(a_stage_end, clock, reset, (state_ff == ST_STAGE) && (phase_ff == 2'd3) && (stage_ff == STAGE_LAST), state_ff == ST_OUT)
   `FSS_ASSERT_IMPL(a_tick_active, clock, reset, state_ff == ST_TICK_SRC, sts.active)

endmodule
`default_nettype wire

[rtl/fss_dp.sv]
`default_nettype none
module fss_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  fss_pkg::dp_cmd_type   ctl_cmd,
   output fss_pkg::dp_sts_type   sts,
   input  logic [7:0]            ctl_byte,
   input  logic [7:0]            fmt_byte [fss_pkg::NUM_FMT],
   input  logic [7:0]            ap_byte,
   input  logic                  csr_wr_en,
   input  logic [2:0]            csr_wr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [13:0]    rsp_sample,
   output logic                  rsp_frame_end
);
   import fss_pkg::*;

   logic [2:0]         mode_ff, mode_in;
   logic [7:0]         ctl_ff, ctl_in;
   logic [7:0]         fmt_ff [NUM_FMT];
   logic [7:0]         fmt_in [NUM_FMT];
   logic [7:0]         ap_ff, ap_in;
   logic signed [13:0] hist0_ff [NUM_STAGES];
   logic signed [13:0] hist0_in [NUM_STAGES];
   logic signed [13:0] hist1_ff [NUM_STAGES];
   logic signed [13:0] hist1_in [NUM_STAGES];
   logic [31:0]        cur_ff [NCOEF];
   logic [31:0]        cur_in [NCOEF];
   logic [31:0]        tgt_ff [NCOEF];
   logic [31:0]        tgt_in [NCOEF];
   logic [31:0]        inc_ff [NCOEF];
   logic [31:0]        inc_in [NCOEF];
   logic [6:0]         fidx_ff [NUM_STAGES];
   logic [6:0]         fidx_in [NUM_STAGES];
   logic [5:0]         bidx_ff [NUM_STAGES];
   logic [5:0]         bidx_in [NUM_STAGES];
   logic [15:0]        pc_ff, pc_in;
   logic [7:0]         flen_ff, flen_in;
   logic [7:0]         sidx_ff, sidx_in;
   logic               active_ff, active_in;
   logic [15:0]        lfsr_ff, lfsr_in;
   logic [1:0]         srcm_ff, srcm_in;
   logic signed [17:0] y_ff, y_in;
   logic signed [29:0] prod_ff, prod_in;
   logic [7:0]         rem_ff, rem_in;
   logic [31:0]        quo_ff, quo_in;
   logic               neg_ff, neg_in;
   logic               vld_ff, vld_in;
   logic signed [13:0] smp_ff, smp_in;
   logic               fend_ff, fend_in;

   logic [7:0]         byte_v;
   logic signed [5:0]  fd6;
   logic signed [3:0]  bd4;
   logic [31:0]        diff;
   logic [8:0]         rem_sh;
   logic [6:0]         amp;
   logic signed [15:0] ip;
   logic [15:0]        thr;
   logic               nbit;
   logic signed [17:0] y0;
   logic signed [14:0] mul_a, mul_b;
   logic signed [17:0] ysub;
   logic signed [13:0] yclp;
   logic [7:0]         sidx_nx;
   logic               last;

   assign sts.active   = active_ff;
   assign sts.out_free = !vld_ff || !rsp_stall;

   assign rsp_valid     = vld_ff;
   assign rsp_sample    = smp_ff;
   assign rsp_frame_end = fend_ff;

   always_comb begin
      mode_in = mode_ff;   ctl_in = ctl_ff;   ap_in = ap_ff;
      fmt_in = fmt_ff;
      hist0_in = hist0_ff; hist1_in = hist1_ff;
      cur_in = cur_ff;     tgt_in = tgt_ff;   inc_in = inc_ff;
      fidx_in = fidx_ff;   bidx_in = bidx_ff;
      pc_in = pc_ff;       flen_in = flen_ff; sidx_in = sidx_ff;
      active_in = active_ff; lfsr_in = lfsr_ff; srcm_in = srcm_ff;
      y_in = y_ff;         prod_in = prod_ff;
      rem_in = rem_ff;     quo_in = quo_ff;   neg_in = neg_ff;
      vld_in = vld_ff;     smp_in = smp_ff;   fend_in = fend_ff;
      byte_v = '0; fd6 = '0; bd4 = '0;
      rem_sh = '0; y0 = '0; ysub = '0; yclp = '0;
      mul_a = '0; mul_b = '0;
      sidx_nx = sidx_ff + 8'd1;
      last = 1'b0;

      // Mode register
      if (csr_wr_en) mode_in = csr_wr_data;

      // Request bytes
      if (ctl_cmd.capture) begin
         ctl_in = ctl_byte;
         fmt_in = fmt_byte;
         ap_in  = ap_byte;
      end

      // Start: frame length, defaults, clear history
      if (ctl_cmd.start) begin
         flen_in = LEN_TAB[mode_ff];
         for (int j = 0; j < NUM_STAGES; j++) begin
            hist0_in[j] = '0;
            hist1_in[j] = '0;
            cur_in[j] = {9'd0, F_INIT[j % 8], 16'd0};
            cur_in[NUM_STAGES + j] = {12'd0, B_INIT[j % 8], 16'd0};
         end
         cur_in[AMP_SLOT]   = '0;
         cur_in[PITCH_SLOT] = DEF_PITCH;
         pc_in     = '0;
         sidx_in   = '0;
         active_in = 1'b0;
      end

      // Load during a frame: finish the old one
      if (ctl_cmd.snap && active_ff) cur_in = tgt_ff;

      // Frame targets
      if (ctl_cmd.set_tgt) begin
         for (int j = 0; j < NUM_STAGES; j++) begin
            byte_v = (j < NUM_FMT) ? fmt_ff[j % NUM_FMT] : 8'd0;
            fd6 = ctl_ff[2] ? {byte_v[7:3], 1'b0} : {byte_v[7], byte_v[7:3]};
            bd4 = ctl_ff[2] ? {byte_v[2:0], 1'b0} : {byte_v[2], byte_v[2:0]};
            tgt_in[j] = cur_ff[j] + {{10{fd6[5]}}, fd6, 16'd0};
            tgt_in[NUM_STAGES + j] = cur_ff[NUM_STAGES + j] + {{12{bd4[3]}}, bd4, 16'd0};
         end
         tgt_in[AMP_SLOT]   = {12'd0, ap_ff[7:4], 16'd0};
         tgt_in[PITCH_SLOT] = cur_ff[PITCH_SLOT] + {{13{ap_ff[2]}}, ap_ff[2:0], 16'd0};
         srcm_in   = ap_ff[2] ? 2'd3 : (ctl_ff[0] ? 2'd1 : 2'd2);
         sidx_in   = '0;
         active_in = 1'b1;
      end

      // Serial divider for the per-sample increment
      diff = tgt_ff[ctl_cmd.slot] - cur_ff[ctl_cmd.slot];
      if (ctl_cmd.div_init) begin
         rem_in = '0;
         neg_in = diff[31];
         quo_in = diff[31] ? (32'd0 - diff) : diff;
      end
      if (ctl_cmd.div_step) begin
         rem_sh = {rem_ff, quo_ff[31]};
         if (rem_sh >= {1'b0, flen_ff}) begin
            rem_in = 8'(rem_sh - {1'b0, flen_ff});
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh[7:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
      end
      if (ctl_cmd.div_store) inc_in[ctl_cmd.slot] = neg_ff ? (32'd0 - quo_ff) : quo_ff;

      // Excitation: pitch pulse and noise
      amp  = AMP_TAB[cur_ff[AMP_SLOT][19:16]];
      ip   = cur_ff[PITCH_SLOT][31:16];
      thr  = (ip > 16'sd0) ? ip : 16'd128;
      nbit = lfsr_ff[0];
      if (ctl_cmd.tick_src) begin
         if (pc_ff > thr) begin
            if (srcm_ff[0]) y0 = $signed({7'd0, amp, 4'd0}) - 18'sd1;
            pc_in = 16'd1;
         end else begin
            pc_in = pc_ff + 16'd1;
         end
         lfsr_in = (lfsr_ff >> 1) ^ (nbit ? 16'hB400 : 16'h0000);
         if (srcm_ff[1] && nbit) y0 = y0 + $signed({9'd0, amp, 2'd0}) - 18'sd1;
         y_in = y0;
         for (int j = 0; j < NUM_STAGES; j++) begin
            fidx_in[j] = cur_ff[j][22:16];
            bidx_in[j] = cur_ff[NUM_STAGES + j][21:16];
         end
      end

      // Two-pole stage: one multiply in each of phases 0 to 2, clamp and history update in phase 3
      if (ctl_cmd.stage_en) begin
         case (ctl_cmd.phase)
            2'd0: begin
               mul_a = 15'(hist0_ff[ctl_cmd.stage]);
               mul_b = POLE_TAB[fidx_ff[ctl_cmd.stage]];
               prod_in = 30'(mul_a) * 30'(mul_b);
            end
            2'd1: begin
               mul_a = 15'(trunc13(prod_ff));
               mul_b = POLE_TAB[{bidx_ff[ctl_cmd.stage], 1'b1}];
               prod_in = 30'(mul_a) * 30'(mul_b);
            end
            2'd2: begin
               mul_a = 15'(hist1_ff[ctl_cmd.stage]);
               mul_b = DAMP_TAB[bidx_ff[ctl_cmd.stage]];
               prod_in = 30'(mul_a) * 30'(mul_b);
               y_in = y_ff + 18'(trunc13(prod_ff));
            end
            default: begin
               ysub = y_ff - 18'(trunc13(prod_ff));
               if (ysub > 18'sd8191) yclp = 14'sd8191;
               else if (ysub < -18'sd8192) yclp = -14'sd8192;
               else yclp = 14'(ysub);
               y_in = 18'(yclp);
               hist1_in[ctl_cmd.stage] = hist0_ff[ctl_cmd.stage];
               hist0_in[ctl_cmd.stage] = yclp;
            end
         endcase
      end

      // Output register
      if (vld_ff && !rsp_stall) vld_in = 1'b0;

      // Interpolate coefficients and emit the sample
      if (ctl_cmd.coef_step) begin
         last = (sidx_nx >= flen_ff);
         for (int j = 0; j < NCOEF; j++) cur_in[j] = cur_ff[j] + inc_ff[j];
         if (last) begin
            cur_in    = tgt_ff;
            active_in = 1'b0;
            sidx_in   = '0;
         end else begin
            sidx_in = sidx_nx;
         end
         vld_in  = 1'b1;
         smp_in  = y_ff[13:0];
         fend_in = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
         for (int j = 0; j < NUM_STAGES; j++) begin
            hist0_ff[j] <= '0;
            hist1_ff[j] <= '0;
            cur_ff[j] <= {9'd0, F_INIT[j % 8], 16'd0};
            cur_ff[NUM_STAGES + j] <= {12'd0, B_INIT[j % 8], 16'd0};
         end
         cur_ff[AMP_SLOT]   <= '0;
         cur_ff[PITCH_SLOT] <= DEF_PITCH;
         for (int j = 0; j < NCOEF; j++) begin
            tgt_ff[j] <= '0;
            inc_ff[j] <= '0;
         end
         pc_ff     <= '0;
         flen_ff   <= 8'd100;
         sidx_ff   <= '0;
         active_ff <= 1'b0;
         lfsr_ff   <= 16'hACE1;
         srcm_ff   <= '0;
         vld_ff    <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         hist0_ff  <= hist0_in;
         hist1_ff  <= hist1_in;
         cur_ff    <= cur_in;
         tgt_ff    <= tgt_in;
         inc_ff    <= inc_in;
         pc_ff     <= pc_in;
         flen_ff   <= flen_in;
         sidx_ff   <= sidx_in;
         active_ff <= active_in;
         lfsr_ff   <= lfsr_in;
         srcm_ff   <= srcm_in;
         vld_ff    <= vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ctl_ff  <= ctl_in;
      fmt_ff  <= fmt_in;
      ap_ff   <= ap_in;
      fidx_ff <= fidx_in;
      bidx_ff <= bidx_in;
      y_ff    <= y_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      smp_ff  <= smp_in;
      fend_ff <= fend_in;
   end

endmodule
`default_nettype wire

[rtl/formant_speech_synth_top.sv]
`default_nettype none
// Formant speech synthesizer: requests carry a command (start, load frame, sample tick)
// and seven parameter bytes; each tick of an active frame returns one 14-bit sample,
// with frame_end set on the frame's last sample. Start requests, and ticks while no
// frame is active, are handled without leaving the idle state. A load request forms
// the twelve increments with a one-bit-per-cycle divider. A sample tick runs its
// filter stages through the single shared 15x15 multiplier that serves three products
// per filter stage; the sample waits in an output register, so the next request is
// taken while it is still pending.
module formant_speech_synth_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [7:0]         req_control_byte,
   input  logic [7:0]         req_formant_byte_1,
   input  logic [7:0]         req_formant_byte_2,
   input  logic [7:0]         req_formant_byte_3,
   input  logic [7:0]         req_formant_byte_4,
   input  logic [7:0]         req_formant_byte_5,
   input  logic [7:0]         req_amp_pitch_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [13:0] rsp_sample,
   output logic               rsp_frame_end,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_wr_data
);
   import fss_pkg::*;

   dp_cmd_type ctl_cmd;
   dp_sts_type sts;
   logic [7:0] fmt_byte [NUM_FMT];

   assign fmt_byte[0] = req_formant_byte_1;
   assign fmt_byte[1] = req_formant_byte_2;
   assign fmt_byte[2] = req_formant_byte_3;
   assign fmt_byte[3] = req_formant_byte_4;
   assign fmt_byte[4] = req_formant_byte_5;

   fss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .sts       (sts),
      .ctl_cmd   (ctl_cmd)
   );

   fss_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctl_cmd       (ctl_cmd),
      .sts           (sts),
      .ctl_byte      (req_control_byte),
      .fmt_byte      (fmt_byte),
      .ap_byte       (req_amp_pitch_byte),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sample    (rsp_sample),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
`default_nettype wire

[test/formant_speech_synth_top_tb.sv]
`default_nettype none
module formant_speech_synth_top_tb;
   import fss_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int LOAD_SETTLE = 450;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_ITEMS = 1950;
   localparam int NUM_ROWS = 24;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_cmd;
   logic [7:0]         req_control_byte;
   logic [7:0]         req_formant_byte_1;
   logic [7:0]         req_formant_byte_2;
   logic [7:0]         req_formant_byte_3;
   logic [7:0]         req_formant_byte_4;
   logic [7:0]         req_formant_byte_5;
   logic [7:0]         req_amp_pitch_byte;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [13:0] rsp_sample;
   logic               rsp_frame_end;
   logic               csr_wr_en;
   logic [2:0]         csr_wr_data;

   formant_speech_synth_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_control_byte(req_control_byte),
      .req_formant_byte_1(req_formant_byte_1), .req_formant_byte_2(req_formant_byte_2),
      .req_formant_byte_3(req_formant_byte_3), .req_formant_byte_4(req_formant_byte_4),
      .req_formant_byte_5(req_formant_byte_5), .req_amp_pitch_byte(req_amp_pitch_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_sample(rsp_sample),
      .rsp_frame_end(rsp_frame_end), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   typedef struct {
      logic signed [13:0] sample;
      logic               frame_end;
   } audio_out_t;

   // one request of the directed table; bytes = {ctl, f1..f5, amp/pitch}
   typedef struct {
      logic [1:0]         cmd;
      logic [55:0]        bytes;
      bit                 typed;
      logic signed [13:0] want_sample;
      logic               want_end;
   } stim_row_t;

   audio_out_t pending_audio[$];
   stim_row_t  rows[NUM_ROWS];

   // synthesizer shadow state
   logic [2:0]  mode_reg;
   int          hist[2*NUM_STAGES];
   logic [31:0] cur[NCOEF];
   logic [31:0] tgt[NCOEF];
   logic [31:0] inc[NCOEF];
   int          pitch_cnt;
   int          frame_len;
   int          sample_idx;
   bit          frame_on;
   logic [15:0] lfsr;
   logic [1:0]  src_mode;

   int  cycles = 0;
   int  requests = 0;
   int  samples_seen = 0;
   int  frames_done = 0;
   int  mismatches = 0;
   bit  calm_tx = 0;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   function automatic void load_default_coefs();
      for (int j = 0; j < NUM_STAGES; j++) begin
         cur[j] = {9'd0, F_INIT[j & 7], 16'd0};
         cur[NUM_STAGES + j] = {12'd0, B_INIT[j & 7], 16'd0};
      end
      cur[AMP_SLOT] = '0;
      cur[PITCH_SLOT] = DEF_PITCH;
   endfunction

   function automatic void synth_reset();
      mode_reg = '0;
      foreach (hist[j]) hist[j] = 0;
      foreach (tgt[j]) begin
         tgt[j] = '0;
         inc[j] = '0;
      end
      load_default_coefs();
      pitch_cnt = 0;
      frame_len = 100;
      sample_idx = 0;
      frame_on = 0;
      lfsr = 16'hACE1;
      src_mode = '0;
   endfunction

   // advance the synthesizer by one request; returns 1 with a sample when one is made
   function automatic bit synth_step(input logic [1:0] cmd, input logic [55:0] bytes,
                                     output audio_out_t res);
      logic [7:0]  ctl, ap, fb;
      int          mul, fd, bd, amp, pc, thr, y, t;
      logic [31:0] diff;
      longint      d;
      bit          nbit;
      ctl = bytes[55:48];
      ap = bytes[7:0];
      res.sample = '0;
      res.frame_end = 0;
      if (cmd == CMD_START) begin
         frame_len = LEN_TAB[mode_reg];
         foreach (hist[j]) hist[j] = 0;
         load_default_coefs();
         pitch_cnt = 0;
         sample_idx = 0;
         frame_on = 0;
         return 0;
      end
      if (cmd == CMD_LOAD) begin
         mul = ctl[2] ? 2 : 1;
         if (frame_on) cur = tgt;
         for (int j = 0; j < NUM_STAGES; j++) begin
            fb = (j < NUM_FMT) ? bytes[47 - 8*j -: 8] : 8'd0;
            fd = int'($signed(fb[7:3])) * mul;
            bd = int'($signed(fb[2:0])) * mul;
            tgt[j] = cur[j] + (32'(fd) << 16);
            tgt[NUM_STAGES + j] = cur[NUM_STAGES + j] + (32'(bd) << 16);
         end
         tgt[AMP_SLOT] = {12'd0, ap[7:4], 16'd0};
         tgt[PITCH_SLOT] = cur[PITCH_SLOT] + (32'(int'($signed(ap[2:0]))) << 16);
         for (int j = 0; j < NCOEF; j++) begin
            diff = tgt[j] - cur[j];
            d = longint'($signed(diff));
            inc[j] = 32'(d / longint'(frame_len));
         end
         src_mode = ctl[0] ? 2'd1 : 2'd2;
         if (ap[2]) src_mode = 2'd3;
         sample_idx = 0;
         frame_on = 1;
         return 0;
      end
      if (cmd != CMD_TICK || !frame_on) return 0;
      // excitation: pitch pulse, then noise
      y = 0;
      amp = int'(AMP_TAB[cur[AMP_SLOT][19:16]]);
      pc = int'($signed(cur[PITCH_SLOT][31:16]));
      thr = (pc > 0) ? pc : 128;
      if (pitch_cnt > thr) begin
         if (src_mode[0]) y = amp * 16 - 1;
         pitch_cnt = 0;
      end
      pitch_cnt = (pitch_cnt + 1) & 16'hFFFF;
      nbit = lfsr[0];
      lfsr = lfsr >> 1;
      if (nbit) lfsr ^= 16'hB400;
      if (src_mode[1] && nbit) y += amp * 4 - 1;
      // cascade of clamped two-pole stages
      for (int j = 0; j < NUM_STAGES; j++) begin
         t = hist[2*j] * int'(POLE_TAB[cur[j][22:16]]) / 8192;
         y += t * int'(POLE_TAB[{cur[NUM_STAGES + j][21:16], 1'b1}]) / 8192;
         y -= hist[2*j + 1] * int'(DAMP_TAB[cur[NUM_STAGES + j][21:16]]) / 8192;
         if (y > 8191) y = 8191;
         if (y < -8192) y = -8192;
         hist[2*j + 1] = hist[2*j];
         hist[2*j] = y;
      end
      for (int j = 0; j < NCOEF; j++) cur[j] += inc[j];
      sample_idx = (sample_idx + 1) & 8'hFF;
      if (sample_idx >= frame_len) begin
         cur = tgt;
         frame_on = 0;
         sample_idx = 0;
         res.frame_end = 1;
      end
      res.sample = 14'(y);
      return 1;
   endfunction

   // drive one request and hold it until accepted
   task automatic send(input logic [1:0] cmd, input logic [55:0] bytes,
                       input bit typed = 0, input logic signed [13:0] ws = 0,
                       input logic we = 0);
      audio_out_t res;
      int gap;
      gap = (!calm_tx && $urandom_range(0, 99) < 32) ? $urandom_range(1, 4) : 0;
      repeat (gap) @(negedge clock);
      req_valid = 1;
      req_cmd = cmd;
      {req_control_byte, req_formant_byte_1, req_formant_byte_2, req_formant_byte_3,
       req_formant_byte_4, req_formant_byte_5, req_amp_pitch_byte} = bytes;
      do @(posedge clock); while (req_stall);
      requests++;
      if (synth_step(cmd, bytes, res)) begin
         if (typed) begin
            res.sample = ws;
            res.frame_end = we;
         end
         pending_audio.push_back(res);
      end
      @(negedge clock);
      req_valid = 0;
   endtask

   // block is idle: every sample back, and a load has had time to finish
   task automatic wait_idle();
      while (pending_audio.size() != 0) @(posedge clock);
      repeat (LOAD_SETTLE) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_mode(input logic [2:0] m);
      csr_wr_en = 1;
      csr_wr_data = m;
      @(negedge clock);
      csr_wr_en = 0;
      mode_reg = m;
   endtask

   function automatic logic [55:0] rand_bytes();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[55:0];
   endfunction

   // result side: random stall, compare with oldest expectation
   always @(negedge clock) begin
      rsp_stall <= !(cycles > 30000 && cycles < 70000) && ($urandom_range(0, 99) < 32);
   end

   always @(posedge clock) begin
      audio_out_t exp_out;
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("formant_speech_synth_top_tb: done, errors");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         samples_seen++;
         if (rsp_frame_end) frames_done++;
         if (pending_audio.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected sample %0d end %0b", rsp_sample, rsp_frame_end);
         end else begin
            exp_out = pending_audio.pop_front();
            if (exp_out.sample !== rsp_sample || exp_out.frame_end !== rsp_frame_end) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("sample %0d: expected %0d end %0b, got %0d end %0b",
                           samples_seen, exp_out.sample, exp_out.frame_end,
                           rsp_sample, rsp_frame_end);
            end
         end
      end
   end

   initial begin
      int cut;
      int nframes;
      synth_reset();
      reset = 1;
      req_valid = 0;
      req_cmd = CMD_TICK;
      {req_control_byte, req_formant_byte_1, req_formant_byte_2, req_formant_byte_3,
       req_formant_byte_4, req_formant_byte_5, req_amp_pitch_byte} = '0;
      rsp_stall = 0;
      csr_wr_en = 0;
      csr_wr_data = '0;

      // directed rows: idle tick, unused command, zero frame, extremes, snap on reload
      rows[0]  = '{CMD_TICK,   56'h0, 0, 0, 0};
      rows[1]  = '{CMD_UNUSED, 56'hFF_FFFF_FFFF_FFFF, 0, 0, 0};
      rows[2]  = '{CMD_LOAD,   56'h01_0000_0000_0000, 0, 0, 0};
      rows[3]  = '{CMD_TICK,   56'h0, 1, 0, 0};
      rows[4]  = '{CMD_LOAD,   56'hFF_FFFF_FFFF_FFFF, 0, 0, 0};
      rows[5]  = '{CMD_TICK,   56'h0, 0, 0, 0};
      rows[6]  = '{CMD_TICK,   56'h0, 0, 0, 0};
      rows[7]  = '{CMD_TICK,   56'h0, 0, 0, 0};
      rows[8]  = '{CMD_TICK,   56'h0, 0, 0, 0};
      rows[9]  = '{CMD_LOAD,   56'h04_8778_8378_80F3, 0, 0, 0};
      rows[10] = '{CMD_TICK,   56'h0, 0, 0, 0};
      rows[11] = '{CMD_TICK,   56'h0, 0, 0, 0};
      rows[12] = '{CMD_TICK,   56'h0, 0, 0, 0};
      rows[13] = '{CMD_TICK,   56'h0, 0, 0, 0};
      rows[14] = '{CMD_START,  56'h0, 0, 0, 0};
      rows[15] = '{CMD_TICK,   56'h0, 0, 0, 0};
      rows[16] = '{CMD_LOAD,   56'h00_0000_0000_0004, 0, 0, 0};
      rows[17] = '{CMD_TICK,   56'h0, 0, 0, 0};
      rows[18] = '{CMD_TICK,   56'h0, 0, 0, 0};
      rows[19] = '{CMD_TICK,   56'h0, 0, 0, 0};
      rows[20] = '{CMD_TICK,   56'h0, 0, 0, 0};
      rows[21] = '{CMD_LOAD,   56'h05_7F80_7F80_07FC, 0, 0, 0};
      rows[22] = '{CMD_TICK,   56'h0, 0, 0, 0};
      rows[23] = '{CMD_TICK,   56'h0, 0, 0, 0};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;
      @(negedge clock);

      foreach (rows[i])
         send(rows[i].cmd, rows[i].bytes, rows[i].typed, rows[i].want_sample,
              rows[i].want_end);

      // random phases: mode change while idle, then start and frames, some cut short, with stray unused commands
      for (int phase = 0; requests < RANDOM_ITEMS + NUM_ROWS; phase++) begin
         wait_idle();
         write_mode(phase == 0 ? 3'd7 : (phase == 1 ? 3'd0 : 3'($urandom_range(0, 7))));
         send(CMD_START, rand_bytes());
         nframes = $urandom_range(1, 3);
         for (int f = 0; f < nframes; f++) begin
            calm_tx = (requests > 700 && requests < 1000);
            send(CMD_LOAD, rand_bytes());
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, frame_len - 1) : frame_len;
            for (int k = 0; k < cut; k++) begin
               calm_tx = (requests > 700 && requests < 1000);
               if ($urandom_range(0, 99) < 2)
                  send(CMD_UNUSED, rand_bytes());
               send(CMD_TICK, rand_bytes());
            end
            if ($urandom_range(0, 3) == 0) send(CMD_TICK, rand_bytes());
         end
         if ($urandom_range(0, 4) == 0) send(CMD_START, rand_bytes());
      end

      while (pending_audio.size() != 0) @(posedge clock);
      repeat (LOAD_SETTLE) @(posedge clock);
      $display("covered %0d requests, %0d samples, %0d complete frames over all speech modes",
               requests, samples_seen, frames_done);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0 && pending_audio.size() == 0)
         $display("formant_speech_synth_top_tb: done, clean");
      else
         $display("formant_speech_synth_top_tb: done, errors");
      $finish;
   end
endmodule
`default_nettype wire
